// ===== design/itod_pkg.sv =====
// ----------------------------------------------------------------------------
// itod_pkg
// Shared widths and the handoff type between the BCD converter and the
// character emitter.
// ----------------------------------------------------------------------------
package itod_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic             valid;
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } itod_bcd_t;

endpackage

// ===== design/itod_bin2bcd.sv =====
// ----------------------------------------------------------------------------
// itod_bin2bcd
// Shift-and-add-3 converter: takes the magnitude one bit per cycle into a
// packed BCD register and hands the digits on with the sign.
// ----------------------------------------------------------------------------
module itod_bin2bcd
    import itod_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   busy,
    output itod_bcd_t              result
);

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    state_t                 state_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic                   neg_reg;
    logic                   done_reg;

    logic [BCD_W-1:0]       corrected;
    logic [BCD_W-1:0]       bcd_next;
    logic [VALUE_WIDTH-1:0] abs_value;

    assign abs_value = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                corrected[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                corrected[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
        bcd_next = {corrected[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (load)
                    begin
                        mag_reg     <= abs_value;
                        neg_reg     <= value[VALUE_WIDTH-1];
                        bcd_reg     <= '0;
                        bit_cnt_reg <= BIT_CNT_W'(VALUE_WIDTH);
                        state_reg   <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    bcd_reg     <= bcd_next;
                    mag_reg     <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result.valid    = done_reg;
    assign result.negative = neg_reg;
    assign result.bcd      = bcd_reg;

endmodule

// ===== design/itod_emitter.sv =====
// ----------------------------------------------------------------------------
// itod_emitter
// Drops leading zero digits one per cycle, then sends the sign and the
// digits most significant first, one character per cycle.
// ----------------------------------------------------------------------------
module itod_emitter
    import itod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  itod_bcd_t          digits,
    output logic               busy,
    output logic               strobe,
    output logic [CHAR_W-1:0]  char_code,
    output logic               is_last,
    output logic [COUNT_W-1:0] char_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t               state_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic                 neg_reg;
    logic [DIG_CNT_W-1:0] len_reg;
    logic [DIG_CNT_W-1:0] remain_reg;
    logic                 strobe_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [3:0]           top_digit;
    logic [31:0]          total;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign total     = 32'(len_reg) + 32'(neg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            len_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (digits.valid)
                    begin
                        bcd_reg   <= digits.bcd;
                        neg_reg   <= digits.negative;
                        len_reg   <= DIG_CNT_W'(NUM_DIGITS);
                        state_reg <= ST_TRIM;
                    end
                end
                ST_TRIM:
                begin
                    if (top_digit == 4'd0 && len_reg > DIG_CNT_W'(1))
                    begin
                        bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
                        len_reg <= len_reg - 1'b1;
                    end
                    else
                    begin
                        remain_reg <= len_reg;
                        state_reg  <= neg_reg ? ST_SIGN : ST_DIGITS;
                    end
                end
                ST_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CHAR_MINUS;
                    last_reg   <= 1'b0;
                    count_reg  <= total[COUNT_W-1:0];
                    state_reg  <= ST_DIGITS;
                end
                ST_DIGITS:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CHAR_ZERO + {4'd0, top_digit};
                    last_reg   <= (remain_reg == DIG_CNT_W'(1));
                    count_reg  <= total[COUNT_W-1:0];
                    bcd_reg    <= {bcd_reg[BCD_W-5:0], 4'd0};
                    remain_reg <= remain_reg - 1'b1;
                    if (remain_reg == DIG_CNT_W'(1))
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign is_last    = last_reg;
    assign char_count = count_reg;

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// From start to the first character: a load, the shift-and-add-3 steps (one
// per magnitude bit), the handoff, the digit check and one trim step per
// dropped leading zero (0..9); then one character per cycle, 1..11 in all.
// A new transaction is accepted only when the BCD converter, the handoff and
// the emitter are all idle, so transactions do not overlap.
// Reset clears both controllers; results cannot be stalled.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import itod_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          strobe,
    output logic [CHAR_W-1:0]             char_code,
    output logic                          is_last,
    output logic [COUNT_W-1:0]            char_count
);

    itod_bcd_t bcd_result;
    logic      conv_busy;
    logic      emit_busy;
    logic      load;

    assign load = start && !busy;
    assign busy = conv_busy || bcd_result.valid || emit_busy;

    itod_bin2bcd u_bin2bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .value  (value),
        .busy   (conv_busy),
        .result (bcd_result)
    );

    itod_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .digits     (bcd_result),
        .busy       (emit_busy),
        .strobe     (strobe),
        .char_code  (char_code),
        .is_last    (is_last),
        .char_count (char_count)
    );

endmodule

// ===== sim/signed_int_to_decimal_ascii_test.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Drives signed integers into the converter and checks every emitted
// character, its last-of-text mark and the text length against a predicted
// decimal rendering. Directed values cover zero, the sign, text lengths 1 to 5,
// 7 and 9 to 11, and both extremes; random values follow, first with idle
// bursts on the command side, then back to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;

    import itod_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0]  code;
        logic               last;
        logic [COUNT_W-1:0] count;
    } text_char_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          strobe;
    logic [CHAR_W-1:0]             char_code;
    logic                          is_last;
    logic [COUNT_W-1:0]            char_count;

    text_char_t expected_chars[$];
    int         error_count = 0;

    signed_int_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .char_code  (char_code),
        .is_last    (is_last),
        .char_count (char_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] number);
        logic [VALUE_WIDTH:0] magnitude;
        logic [3:0]           digit_stack[$];
        logic                 negative;
        int                   total;
        text_char_t           ch;
        negative  = number[VALUE_WIDTH-1];
        magnitude = negative ? ({1'b0, ~number} + 1'b1) : {1'b0, number};
        do
        begin
            digit_stack.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        total = digit_stack.size() + (negative ? 1 : 0);
        if (negative)
        begin
            ch.code  = CHAR_MINUS;
            ch.last  = 1'b0;
            ch.count = COUNT_W'(total);
            expected_chars.push_back(ch);
        end
        foreach (digit_stack[i])
        begin
            ch.code  = CHAR_ZERO + CHAR_W'(digit_stack[i]);
            ch.last  = (i == digit_stack.size() - 1);
            ch.count = COUNT_W'(total);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] random_number();
        int unsigned digits;
        int unsigned lo;
        int unsigned hi;
        int unsigned magnitude;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        digits = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < digits; i++)
            lo = lo * 10;
        if (digits == 1)
            lo = 0;
        hi = (digits == 10) ? 32'h7fffffff : ((digits == 1) ? 9 : lo * 10 - 1);
        magnitude = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 1)
            return -$signed(magnitude);
        return $signed(magnitude);
    endfunction

    // Hold start and value until the transaction is accepted.
    task automatic send_number(input logic signed [VALUE_WIDTH-1:0] number,
                               input bit allow_idle);
        if (allow_idle && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11))
            begin
                value <= $urandom;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        value <= number;
        do
            @(posedge clk);
        while (busy);
        predict_text(number);
    endtask

    always @(posedge clk)
    begin : check_result
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h/%b/%0d",
                         $time, char_code, is_last, char_count);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $display("%0t: char_code mismatch: expected %h, actual %h",
                             $time, want.code, char_code);
                    error_count++;
                end
                if (is_last !== want.last)
                begin
                    $display("%0t: is_last mismatch: expected %b, actual %b",
                             $time, want.last, is_last);
                    error_count++;
                end
                if (char_count !== want.count)
                begin
                    $display("%0t: char_count mismatch: expected %0d, actual %0d",
                             $time, want.count, char_count);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_values();
        logic signed [VALUE_WIDTH-1:0] directed[$];
        directed = '{0, 1, -1, 9, -10, 99, -100, 12345, -987654, 1000000000,
                     999999999, -1000000000, 32'sh7fffffff, -32'sh7fffffff,
                     32'sh80000000, 32'sh55555555, 32'shaaaaaaaa};
        foreach (directed[i])
            send_number(directed[i], 1'b1);
    endtask

    task automatic test_random_values();
        repeat (113)
            send_number(random_number(), 1'b1);
    endtask

    task automatic test_back_to_back();
        repeat (30)
            send_number(random_number(), 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_values();
        test_random_values();
        test_back_to_back();
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("signed_int_to_decimal_ascii_test: clean");
        else
            $display("signed_int_to_decimal_ascii_test: errors");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("%0t: timeout with %0d characters outstanding", $time, expected_chars.size());
        $display("signed_int_to_decimal_ascii_test: errors");
        $finish;
    end

endmodule
